>>> sv/wma_pkg.sv
// Shared types and constants for the weighted mean accumulator.
// No dependencies; every other file imports this package.
package wma_pkg;

	// Fixed width of the payload fields on the channels.
	localparam int DATA_BITS = 64;

	// Depth of the snapshot queue between the accumulate and divide units.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_BITS = 1;
	localparam int QUEUE_CNT_BITS = 2;

	typedef logic [DATA_BITS-1:0] data_t;

	// Status of the snapshot queue, seen by both of its neighbors.
	typedef struct packed {
		logic full;
		logic empty;
	} wma_q_stat_t;

endpackage

>>> sv/wma_in_if.sv
// Input channel: valid/ready handshake carrying restart, value and weight.
// Depends on wma_pkg.
interface wma_in_if import wma_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  restart;
	data_t value;
	data_t weight;

	modport source (output valid, restart, value, weight, input ready);
	modport sink (input valid, restart, value, weight, output ready);
endinterface

>>> sv/wma_out_if.sv
// Result channel: valid/ready handshake carrying mean and overflow.
// Depends on wma_pkg.
interface wma_out_if import wma_pkg::*; ();
	logic  valid;
	logic  ready;
	data_t mean;
	logic  overflow;

	modport source (output valid, mean, overflow, input ready);
	modport sink (input valid, mean, overflow, output ready);
endinterface

>>> sv/wma_front.sv
// Front end: accepts transactions, forms the double-width product from four
// half-width partial products and updates the running sum and weight total.
// Depends on wma_pkg and wma_in_if.
module wma_front import wma_pkg::*; #(
	parameter int W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	wma_in_if.sink            items,
	input  wma_q_stat_t       q_stat,
	output logic              push,
	output logic [3*W-1:0]    push_data
);

	localparam int H   = (W + 1) / 2;
	localparam int SHW = $clog2(2 * W);

	typedef enum logic [1:0] {IDLE, MUL, ACC} state_t;

	state_t         state_q;
	logic [2:0]     cnt_q;
	logic           restart_q;
	logic [W-1:0]   a_q;
	logic [W-1:0]   b_q;
	logic [2*H-1:0] pp_q;
	logic [2*W-1:0] prod_q;
	logic [2*W-1:0] sum_q;
	logic [W-1:0]   wsum_q;

	logic [2*H-1:0] a_ext;
	logic [2*H-1:0] b_ext;
	logic [H-1:0]   a_sel;
	logic [H-1:0]   b_sel;
	logic [2*H-1:0] pp_next;
	logic [1:0]     p_idx;
	logic [SHW-1:0] shamt;
	logic [2*W-1:0] pp_shift;
	logic [2*W-1:0] sum_new;
	logic [W-1:0]   wsum_new;

	always_comb begin
		a_ext    = (2*H)'(a_q);
		b_ext    = (2*H)'(b_q);
		a_sel    = cnt_q[1] ? a_ext[2*H-1:H] : a_ext[H-1:0];
		b_sel    = cnt_q[0] ? b_ext[2*H-1:H] : b_ext[H-1:0];
		pp_next  = {{H{1'b0}}, a_sel} * {{H{1'b0}}, b_sel};
		p_idx    = cnt_q[1:0] - 2'd1;
		case (p_idx)
			2'd0:    shamt = '0;
			2'd3:    shamt = SHW'(2 * H);
			default: shamt = SHW'(H);
		endcase
		pp_shift = (2*W)'(pp_q) << shamt;
		// restart drops the old accumulation before this item is added
		sum_new  = (restart_q ? '0 : sum_q) + prod_q;
		wsum_new = (restart_q ? '0 : wsum_q) + b_q;
	end

	assign items.ready = (state_q == IDLE);
	assign push        = (state_q == ACC) && !q_stat.full;
	assign push_data   = {sum_new, wsum_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
			sum_q   <= '0;
			wsum_q  <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (items.valid) begin
						state_q <= MUL;
						cnt_q   <= '0;
					end
				end
				MUL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= ACC;
					end
				end
				ACC: begin
					if (!q_stat.full) begin
						sum_q   <= sum_new;
						wsum_q  <= wsum_new;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// Operand and product datapath, no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == IDLE && items.valid) begin
			a_q       <= items.value[W-1:0];
			b_q       <= items.weight[W-1:0];
			restart_q <= items.restart;
			prod_q    <= '0;
		end
		if (state_q == MUL) begin
			if (cnt_q != 3'd4) begin
				pp_q <= pp_next;
			end
			if (cnt_q != 3'd0) begin
				prod_q <= prod_q + pp_shift;
			end
		end
	end

endmodule

>>> sv/wma_queue.sv
// Two-entry snapshot queue between the accumulate front end and the divider.
// Depends on wma_pkg.
module wma_queue import wma_pkg::*; #(
	parameter int DW = 192
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic [DW-1:0] head,
	output wma_q_stat_t   stat
);

	logic [DW-1:0]             mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QUEUE_CNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QUEUE_CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("queue read while empty");
`endif

endmodule

>>> sv/wma_back.sv
// Back end: restoring divider, one quotient bit per cycle, plus result register.
// Depends on wma_pkg and wma_out_if.
module wma_back import wma_pkg::*; #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [3*W-1:0] head,
	input  wma_q_stat_t    q_stat,
	output logic           pop,
	wma_out_if.source      results
);

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	typedef enum logic [1:0] {IDLE, DIV, FIN} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  lo_q;
	logic [W-1:0]  d_q;
	logic [W-1:0]  quo_q;
	logic          sat_q;
	logic          out_valid_q;
	data_t         mean_q;
	logic          ovf_q;

	logic [W-1:0]  h_hi;
	logic [W-1:0]  h_lo;
	logic [W-1:0]  h_w;
	logic          h_sat;
	logic [W-1:0]  rs;
	logic          ge;
	logic [W-1:0]  r_next;
	logic          out_free;

	always_comb begin
		h_hi     = head[3*W-1:2*W];
		h_lo     = head[2*W-1:W];
		h_w      = head[W-1:0];
		h_sat    = (h_w == '0) || (h_hi >= h_w);
		rs       = {r_q[W-2:0], lo_q[W-1]};
		ge       = r_q[W-1] || (rs >= d_q);
		r_next   = ge ? (rs - d_q) : rs;
		out_free = !out_valid_q || results.ready;
	end

	assign pop              = (state_q == IDLE) && !q_stat.empty;
	assign results.valid    = out_valid_q;
	assign results.mean     = mean_q;
	assign results.overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// load a new result, or drop the one just taken
			if (state_q == FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (!q_stat.empty) begin
						state_q <= h_sat ? FIN : DIV;
						cnt_q   <= CW'(W - 1);
					end
				end
				DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						state_q <= FIN;
					end
				end
				FIN: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && !q_stat.empty) begin
			r_q   <= h_hi;
			lo_q  <= h_lo;
			d_q   <= h_w;
			sat_q <= h_sat;
			quo_q <= h_sat ? '1 : '0;
		end
		if (state_q == DIV) begin
			r_q   <= r_next;
			lo_q  <= {lo_q[W-2:0], 1'b0};
			quo_q <= {quo_q[W-2:0], ge};
		end
		if (state_q == FIN && out_free) begin
			mean_q <= DATA_BITS'(quo_q);
			ovf_q  <= sat_q;
		end
	end

`ifndef SYNTHESIS
	a_ovf_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.overflow) |-> (results.mean == DATA_BITS'({W{1'b1}})))
		else $error("saturated mean is not all ones");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DIV) |-> (d_q != '0 && !sat_q))
		else $error("divider running on a saturated snapshot");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |=> (out_valid_q && $stable(mean_q)))
		else $error("pending result overwritten");
`endif

endmodule

>>> sv/weighted_mean_accumulator_top.sv
// Weighted mean accumulator: running sum of value*weight over the weight total.
// The front end takes a new transaction while the bit-serial divider still works on
// earlier snapshots held in the queue, so the divider sets the throughput;
// saturated results skip the divide steps.
// Reset (arst_n, async, active low) clears sum, weight total, queue and valids.
module weighted_mean_accumulator_top import wma_pkg::*; #(
	parameter int WORD_BITS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	wma_in_if.sink    items,
	wma_out_if.source results
);

	// Snapshot of {sum upper, sum lower, weight total} after each item.
	logic [3*WORD_BITS-1:0] push_data;
	logic [3*WORD_BITS-1:0] head;
	logic                   push;
	logic                   pop;
	wma_q_stat_t            q_stat;

	// Front end: multiply from four partial products, then fold into the running sum and
	// hand the updated state to the queue; hold in accumulate while it is full.
	wma_front #(.W(WORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// Decouple the accumulate and divide units so each may stall on its own.
	wma_queue #(.DW(3 * WORD_BITS)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// Back end: restoring division of the 2*WORD_BITS sum by the weight total;
	// saturate to all ones with overflow on zero weight or an unfitting quotient.
	wma_back #(.W(WORD_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_stat  (q_stat),
		.pop     (pop),
		.results (results)
	);

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for weighted_mean_accumulator_top: directed and random samples,
// a built-in weighted mean predictor, and a scoreboard of expected means.
// Depends on wma_pkg, wma_in_if, wma_out_if and the accumulator RTL.
module tb_top;
	import wma_pkg::*;

	localparam int WORD_BITS = 64;
	localparam int RANDOM_SAMPLES = 1430;
	// Long receiver hold-off, applied twice, so the front end and queue fill up.
	localparam int HOLD_CYCLES = 600;
	localparam int FIRST_HOLD_AT = 200;
	localparam int SECOND_HOLD_AT = 900;
	// Worst quiet stretch: a hold-off, a long sender gap, one divide pass and latency.
	localparam int STALL_LIMIT = 4 * (HOLD_CYCLES + 140 + WORD_BITS + 2 + WORD_BITS + 9);
	localparam int DRAIN_CYCLES = 2 * (WORD_BITS + 9);

	localparam data_t ALL_ONES = '1;
	localparam data_t TOP_BIT = data_t'(1) << (DATA_BITS - 1);
	localparam data_t ODD_BITS = {(DATA_BITS / 2){2'b01}};
	localparam data_t EVEN_BITS = {(DATA_BITS / 2){2'b10}};

	typedef struct packed {
		logic  restart;
		data_t value;
		data_t weight;
	} sample_t;

	typedef struct packed {
		data_t mean;
		logic  overflow;
	} mean_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wma_in_if  items_if ();
	wma_out_if results_if ();

	weighted_mean_accumulator_top #(
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	// Predictor state: double-width running sum and the running weight total.
	logic [2*WORD_BITS-1:0] run_sum = '0;
	logic [WORD_BITS-1:0]   run_weight = '0;

	sample_t pending_samples[$];
	mean_t   expected_means[$];

	// Handoff between the rising-edge monitor and the falling-edge driver.
	bit      in_taken = 1'b0;
	bit      offering = 1'b0;
	sample_t current = '0;
	int      burst_left = 0;
	int      gap_left = 0;

	int results_seen = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	int            hold_left = 0;
	int            holds_done = 0;
	int            pat_age = 0;
	logic [15:0]   stall_pat = '1;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Advance the running sum and weight total by one sample and return the mean the
	// block must report. Saturate when the weight total is zero or the quotient does
	// not fit in one word (upper half of the sum not below the divisor).
	function automatic mean_t predict_mean(sample_t s);
		logic [WORD_BITS-1:0]   v;
		logic [WORD_BITS-1:0]   w;
		logic [2*WORD_BITS-1:0] prod;
		logic [2*WORD_BITS-1:0] quo;
		mean_t                  r;
		v = s.value[WORD_BITS-1:0];
		w = s.weight[WORD_BITS-1:0];
		if (s.restart) begin
			run_sum = '0;
			run_weight = '0;
		end
		run_weight = run_weight + w;
		prod = {{WORD_BITS{1'b0}}, v} * {{WORD_BITS{1'b0}}, w};
		run_sum = run_sum + prod;
		r = '0;
		if (run_weight == '0 || run_sum[2*WORD_BITS-1:WORD_BITS] >= run_weight) begin
			r.mean[WORD_BITS-1:0] = '1;
			r.overflow = 1'b1;
		end else begin
			quo = run_sum / {{WORD_BITS{1'b0}}, run_weight};
			r.mean[WORD_BITS-1:0] = quo[WORD_BITS-1:0];
			r.overflow = 1'b0;
		end
		return r;
	endfunction

	function automatic void queue_sample(logic restart, data_t value, data_t weight);
		sample_t s;
		s.restart = restart;
		s.value = value;
		s.weight = weight;
		pending_samples = {pending_samples, s};
	endfunction

	// Pick a word from a mix of shapes: full random, small, sparse, half width, extremes.
	function automatic data_t random_word();
		data_t w;
		case ($urandom_range(9))
			0, 1, 2, 3: w = {$urandom(), $urandom()};
			4, 5:       w = data_t'($urandom_range(1000));
			6: begin
				case ($urandom_range(4))
					0:       w = '0;
					1:       w = data_t'(1);
					2:       w = ALL_ONES;
					3:       w = TOP_BIT;
					default: w = ALL_ONES - 1;
				endcase
			end
			7:       w = data_t'(1) << $urandom_range(DATA_BITS - 1);
			default: w = data_t'($urandom());
		endcase
		return w;
	endfunction

	// Monitor: sample both channels on the rising edge, predict on each input
	// transaction, compare each result transaction with the oldest expected mean.
	always @(posedge clk) begin
		bit    progress;
		mean_t got;
		mean_t want;
		sample_t seen;
		if (arst_n) begin
			progress = 1'b0;
			if (items_if.valid && items_if.ready) begin
				seen.restart = items_if.restart;
				seen.value = items_if.value;
				seen.weight = items_if.weight;
				want = predict_mean(seen);
				expected_means = {expected_means, want};
				in_taken = 1'b1;
				progress = 1'b1;
			end
			if (results_if.valid && results_if.ready) begin
				progress = 1'b1;
				results_seen++;
				got.mean = results_if.mean;
				got.overflow = results_if.overflow;
				if (expected_means.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: mean=%h overflow=%b",
							got.mean, got.overflow);
					mismatches++;
				end else begin
					want = expected_means.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display("result %0d: expected mean=%h overflow=%b, got mean=%h overflow=%b",
								results_seen, want.mean, want.overflow, got.mean, got.overflow);
						mismatches++;
					end
				end
			end
			idle_cycles = progress ? 0 : idle_cycles + 1;
			// Drop the run if nothing moves on either channel for too long.
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Driver: on the falling edge, drop an accepted sample and offer the next one.
	// Work in bursts of random length with random gaps between them; some bursts are
	// long and gap-free so the block sees back-to-back input.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				in_taken = 1'b0;
				offering = 1'b0;
			end
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_samples.size() > 0) begin
					current = pending_samples.pop_front();
					offering = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else if ($urandom_range(4) == 0) begin
						burst_left = $urandom_range(60, 30);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(6, 1);
						gap_left = ($urandom_range(7) == 0) ? $urandom_range(140, 60)
							: $urandom_range(12);
					end
				end
			end
			items_if.valid <= offering;
			items_if.restart <= current.restart;
			items_if.value <= current.value;
			items_if.weight <= current.weight;
		end
	end

	// Receiver: stall on a rotating 16-bit pattern, reloaded once it ages out (a quarter
	// of the time with no stalls at all). Twice in the run, hold ready low for a long
	// stretch while the sender keeps offering, so the block backs up into its input.
	always @(negedge clk) begin
		logic ready_now;
		if (arst_n) begin
			if (holds_done < 2 &&
				results_seen >= ((holds_done == 0) ? FIRST_HOLD_AT : SECOND_HOLD_AT)) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_now = 1'b0;
			end else begin
				if (pat_age == 0) begin
					pat_age = 48;
					stall_pat = ($urandom_range(3) == 0) ? 16'hffff
						: (16'($urandom()) | 16'h0001);
				end
				pat_age--;
				ready_now = stall_pat[0];
				stall_pat = {stall_pat[0], stall_pat[15:1]};
			end
			results_if.ready <= ready_now;
		end
	end

	initial begin
		int run_left;
		int target;
		logic restart;
		items_if.valid = 1'b0;
		items_if.restart = 1'b0;
		items_if.value = '0;
		items_if.weight = '0;
		results_if.ready = 1'b0;

		// Zero weight total, first from a restart and then still zero after a sample.
		queue_sample(1'b1, '0, '0);
		queue_sample(1'b0, ALL_ONES, '0);
		// Largest value at unit weight: mean is the value itself.
		queue_sample(1'b0, ALL_ONES, data_t'(1));
		// Weight total wraps to zero.
		queue_sample(1'b0, data_t'(5), ALL_ONES);
		// Full-width products: every partial product and carry in play, then the
		// running sum wraps past its double width.
		queue_sample(1'b1, ALL_ONES, ALL_ONES);
		queue_sample(1'b0, ALL_ONES, ALL_ONES);
		// Quotient too wide: weight total wraps to a small number under a huge sum.
		queue_sample(1'b1, ALL_ONES, ALL_ONES);
		queue_sample(1'b0, '0, data_t'(2));
		// Zero mean and top-bit operands.
		queue_sample(1'b1, '0, data_t'(1));
		queue_sample(1'b1, TOP_BIT, TOP_BIT);
		queue_sample(1'b0, TOP_BIT, data_t'(1));
		// Alternating bit patterns in both fields.
		queue_sample(1'b1, ODD_BITS, EVEN_BITS);
		queue_sample(1'b0, EVEN_BITS, ODD_BITS);
		// Small running mean with a fraction to floor.
		queue_sample(1'b1, data_t'(12345), data_t'(7));
		queue_sample(1'b0, data_t'(1), data_t'(3));
		queue_sample(1'b0, '0, data_t'(1));
		// Restart with zero weight on a loaded accumulator.
		queue_sample(1'b1, ALL_ONES, '0);
		// Zero weight keeps the previous sum and weight total.
		queue_sample(1'b0, data_t'(9), data_t'(4));
		queue_sample(1'b0, ALL_ONES, '0);
		queue_sample(1'b0, '0, ALL_ONES - 1);

		// Random runs: each opens with a restart, mostly short, some long enough for the
		// weight total to wrap; a few stray restarts break runs in the middle.
		target = pending_samples.size() + RANDOM_SAMPLES;
		run_left = 0;
		while (pending_samples.size() < target) begin
			if (run_left == 0) begin
				case ($urandom_range(19))
					0:                   run_left = $urandom_range(250, 100);
					1, 2, 3, 4, 5:       run_left = $urandom_range(60, 13);
					default:             run_left = $urandom_range(12, 1);
				endcase
				restart = 1'b1;
			end else begin
				restart = ($urandom_range(32) == 0);
			end
			run_left--;
			queue_sample(restart, random_word(), random_word());
		end

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Hold until every sample is accepted, then until every mean has arrived,
		// then watch a while longer for stray results.
		while (pending_samples.size() != 0 || offering)
			@(posedge clk);
		while (expected_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_means.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
